>>> sv/fwss_pkg.sv
// Shared types and constants for the FIFO with search and statistics.
package fwss_pkg;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int OCC_W    = 11;
    localparam int TOTAL_W  = 42;
    localparam int MEAN_W   = 40;
    localparam int FRAC_W   = 8;

    // slave tdata: value, key
    localparam int S_DATA_W = 64;
    // master tdata: head, occupancy, total, largest, smallest, key_found, mean, pad
    localparam int M_DATA_W = 192;

    localparam logic signed [WORD_W-1:0] WORD_NONE = '1;
    localparam logic signed [WORD_W-1:0] WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

>>> sv/fwss_ram.sv
// Generic simple dual-port RAM with registered read data.
module fwss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/fifo_with_search_and_stats_core.sv
// Top level: bounded FIFO of signed words with head, sum, min/max, key search and mean.
//
// A bounded first-in first-out store of DEPTH signed 32-bit words. Each slave
// transfer carries an action in tuser (push, pop, clear or query) plus a value
// and a search key; each produces exactly one master transfer reporting, after
// the action, a status (done, push refused full, pop refused empty) and the
// oldest word (-1 when empty), the occupancy, the exact sum, the largest and
// smallest word (INT_MIN / INT_MAX when empty), whether the key is held, and
// the mean as signed Q.8 truncated toward zero (0 when empty). The block works
// on one transfer at a time; tready is low from acceptance until the result
// has been taken. The walk reads the held entries through the single read
// port of the entry RAM, one word per cycle; the mean comes from a restoring
// divider, which produces one quotient bit per cycle on the same shared adder
// that accumulates the sum. The entry RAM needs no clearing after reset: only
// words written by a push are ever read.
module fifo_with_search_and_stats_core #(
    parameter int DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [31:0] value, [63:32] key
    input  logic [fwss_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] action
    input  logic [fwss_pkg::ACTION_W-1:0]  i_s_axis_tuser,
    // master stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [31:0] head_value, [42:32] occupancy, [84:43] total, [116:85] largest,
    // [148:117] smallest, [149] key_found, [189:150] mean_q8, [191:190] zero
    output logic [fwss_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    // [1:0] status
    output logic [fwss_pkg::STATUS_W-1:0]  o_m_axis_tuser
);
    import fwss_pkg::*;

    localparam int AW    = $clog2(DEPTH);          // entry index
    localparam int CW    = $clog2(DEPTH + 1);      // count, holds DEPTH itself
    localparam int SUMW  = WORD_W + CW;            // exact signed sum
    localparam int DW    = SUMW + FRAC_W;          // dividend / quotient / adder
    localparam int STEPW = $clog2(DW + 1);

    localparam logic [AW-1:0]     LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0]     FULL_CNT  = CW'(DEPTH);
    localparam logic [CW:0]       DEPTH_EXT = (CW + 1)'(DEPTH);
    localparam logic [STEPW-1:0]  DIV_STEPS = STEPW'(DW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_ABS,
        S_DIV,
        S_SIGN,
        S_OUT
    } t_state;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state                    r_state,  n_state;
    logic [AW-1:0]             r_head,   n_head;      // index of oldest word
    logic [CW-1:0]             r_count,  n_count;     // words held
    logic [AW-1:0]             r_rd_ptr, n_rd_ptr;    // walk read address
    logic [CW-1:0]             r_iss,    n_iss;       // reads issued so far
    logic                      r_pend,   n_pend;      // read data arrives this cycle
    logic                      r_first,  n_first;     // next returned word is the head
    logic signed [WORD_W-1:0]  r_key,    n_key;
    t_status                   r_status, n_status;
    logic signed [WORD_W-1:0]  r_hval,   n_hval;
    logic signed [SUMW-1:0]    r_sum,    n_sum;
    logic signed [WORD_W-1:0]  r_big,    n_big;
    logic signed [WORD_W-1:0]  r_small,  n_small;
    logic                      r_found,  n_found;
    logic                      r_neg,    n_neg;       // sum was negative
    logic [CW-1:0]             r_rem,    n_rem;       // divider remainder
    logic [DW-1:0]             r_quo,    n_quo;       // dividend in, quotient out
    logic [STEPW-1:0]          r_step,   n_step;
    logic                      r_mvalid, n_mvalid;

    // ---------------------------------------------------------------
    // Entry RAM
    // ---------------------------------------------------------------
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic                      ram_re;
    logic [WORD_W-1:0]         ram_rdata;
    logic signed [WORD_W-1:0]  word;

    fwss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_axis_tdata[WORD_W-1:0]),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign word = signed'(ram_rdata);

    // ---------------------------------------------------------------
    // Shared adder: sum accumulation, negation and divider trial subtract
    // ---------------------------------------------------------------
    logic [DW-1:0]  alu_a;
    logic [DW-1:0]  alu_b;
    logic           alu_cin;
    logic [DW-1:0]  alu_y;
    logic [CW:0]    div_shift;   // remainder shifted left with next dividend bit

    assign div_shift = {r_rem, r_quo[DW-1]};
    assign alu_y     = alu_a + alu_b + DW'(alu_cin);

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        case (r_state)
            S_WALK: begin
                alu_a = DW'(r_sum);
                alu_b = DW'(word);
            end
            S_ABS: begin
                alu_b   = ~DW'(r_sum);
                alu_cin = 1'b1;
            end
            S_DIV: begin
                alu_a   = DW'(div_shift);
                alu_b   = ~DW'(r_count);
                alu_cin = 1'b1;
            end
            S_SIGN: begin
                alu_b   = ~r_quo;
                alu_cin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic           s_fire;
    logic           m_fire;
    t_action        act;
    logic [CW:0]    tail_sum;
    logic [AW-1:0]  tail_idx;
    logic           walk_done;

    assign s_fire    = i_s_axis_tvalid && o_s_axis_tready;
    assign m_fire    = r_mvalid && i_m_axis_tready;
    assign act       = t_action'(i_s_axis_tuser);
    assign tail_sum  = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign tail_idx  = (tail_sum >= DEPTH_EXT) ? AW'(tail_sum - DEPTH_EXT) : AW'(tail_sum);
    assign walk_done = (r_iss == r_count) && !r_pend;
    assign ram_re    = (r_state == S_WALK) && (r_iss != r_count);
    assign ram_waddr = tail_idx;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_rd_ptr = r_rd_ptr;
        n_iss    = r_iss;
        n_pend   = 1'b0;
        n_first  = r_first;
        n_key    = r_key;
        n_status = r_status;
        n_hval   = r_hval;
        n_sum    = r_sum;
        n_big    = r_big;
        n_small  = r_small;
        n_found  = r_found;
        n_neg    = r_neg;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_step   = r_step;
        n_mvalid = r_mvalid;
        ram_we   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_status = ST_DONE;
                    case (act)
                        ACT_PUSH: begin
                            if (r_count == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                                n_count = r_count - 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_key    = signed'(i_s_axis_tdata[2*WORD_W-1:WORD_W]);
                    n_rd_ptr = n_head;
                    n_iss    = '0;
                    n_first  = 1'b1;
                    n_hval   = WORD_NONE;
                    n_sum    = '0;
                    n_big    = WORD_MIN;
                    n_small  = WORD_MAX;
                    n_found  = 1'b0;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                if (r_iss != r_count) begin
                    n_pend   = 1'b1;
                    n_iss    = r_iss + 1'b1;
                    n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
                end
                if (r_pend) begin
                    n_first = 1'b0;
                    if (r_first) begin
                        n_hval = word;
                    end
                    n_sum = SUMW'(alu_y);
                    if (word > r_big) begin
                        n_big = word;
                    end
                    if (word < r_small) begin
                        n_small = word;
                    end
                    if (word == r_key) begin
                        n_found = 1'b1;
                    end
                end
                if (walk_done) begin
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                n_neg = r_sum[SUMW-1];
                n_rem = '0;
                n_step = DIV_STEPS;
                if (r_sum[SUMW-1]) begin
                    n_quo = {alu_y[SUMW-1:0], {FRAC_W{1'b0}}};
                end else begin
                    n_quo = {r_sum, {FRAC_W{1'b0}}};
                end
                if (r_count == '0) begin
                    n_quo    = '0;
                    n_mvalid = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (alu_y[DW-1]) begin
                    n_rem = CW'(div_shift);
                    n_quo = {r_quo[DW-2:0], 1'b0};
                end else begin
                    n_rem = CW'(alu_y);
                    n_quo = {r_quo[DW-2:0], 1'b1};
                end
                n_step = r_step - 1'b1;
                if (r_step == STEPW'(1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (r_neg) begin
                    n_quo = alu_y;
                end
                n_mvalid = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (m_fire) begin
                    n_mvalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_iss    <= '0;
            r_pend   <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_iss    <= n_iss;
            r_pend   <= n_pend;
            r_mvalid <= n_mvalid;
        end
        r_rd_ptr <= n_rd_ptr;
        r_first  <= n_first;
        r_key    <= n_key;
        r_status <= n_status;
        r_hval   <= n_hval;
        r_sum    <= n_sum;
        r_big    <= n_big;
        r_small  <= n_small;
        r_found  <= n_found;
        r_neg    <= n_neg;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_step   <= n_step;
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    logic signed [TOTAL_W-1:0] total_out;
    logic signed [MEAN_W-1:0]  mean_out;
    logic [OCC_W-1:0]          occ_out;

    assign total_out = TOTAL_W'(r_sum);
    assign mean_out  = MEAN_W'(signed'(r_quo));
    assign occ_out   = OCC_W'(r_count);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {2'b00, mean_out, r_found, r_small, r_big, total_out,
                              occ_out, r_hval};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_ready_excl_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("input ready while a result is pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("held count exceeds depth");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_iss <= r_count))
        else $error("walk read past held entries");

    a_result_then_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready) |=> o_s_axis_tready)
        else $error("not ready after result transfer");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_m_axis_tvalid)
        else $error("result raised in the cycle after acceptance");

endmodule

>>> sim/tb_fifo_with_search_and_stats_core.sv
// Testbench for the FIFO with search and statistics: stream stimulus, own predictor, scoreboard.
module tb_fifo_with_search_and_stats_core;

    import fwss_pkg::*;

    localparam int DEPTH = 1024;

    // Report for one transfer, typed at the widths of the master stream.
    typedef struct packed {
        t_status                   status;
        logic signed [WORD_W-1:0]  head;
        logic [OCC_W-1:0]          occ;
        logic signed [TOTAL_W-1:0] total;
        logic signed [WORD_W-1:0]  largest;
        logic signed [WORD_W-1:0]  smallest;
        logic                      found;
        logic signed [MEAN_W-1:0]  mean;
    } fifo_report_t;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        t_action                  act;
        logic signed [WORD_W-1:0] word;
        logic signed [WORD_W-1:0] key;
        logic                     typed;
        fifo_report_t             want;
    } stim_row_t;

    localparam fifo_report_t UNTYPED = '0;
    localparam fifo_report_t EMPTY_DONE = '{status: ST_DONE, head: WORD_NONE, occ: '0,
        total: '0, largest: WORD_MIN, smallest: WORD_MAX, found: 1'b0, mean: '0};
    localparam fifo_report_t EMPTY_REFUSED = '{status: ST_EMPTY, head: WORD_NONE, occ: '0,
        total: '0, largest: WORD_MIN, smallest: WORD_MAX, found: 1'b0, mean: '0};
    // A single INT_MIN held: the most negative mean the Q.8 field can carry.
    localparam fifo_report_t ONE_MIN = '{status: ST_DONE, head: WORD_MIN, occ: 11'd1,
        total: -42'sd2147483648, largest: WORD_MIN, smallest: WORD_MIN, found: 1'b1,
        mean: -40'sd549755813888};

    localparam stim_row_t DIRECTED [25] = '{
        '{ACT_QUERY, 32'sd0,        32'sd0,        1'b1, EMPTY_DONE},
        '{ACT_POP,   WORD_MAX,      32'sd0,        1'b1, EMPTY_REFUSED},
        '{ACT_CLEAR, WORD_MIN,      WORD_NONE,     1'b1, EMPTY_DONE},
        '{ACT_PUSH,  WORD_MIN,      WORD_MIN,      1'b1, ONE_MIN},
        '{ACT_QUERY, 32'sd7,        WORD_MAX,      1'b0, UNTYPED},
        '{ACT_PUSH,  WORD_MAX,      WORD_MAX,      1'b0, UNTYPED},
        '{ACT_PUSH,  WORD_NONE,     32'sd0,        1'b0, UNTYPED},
        '{ACT_PUSH,  32'sd0,        WORD_NONE,     1'b0, UNTYPED},
        '{ACT_PUSH,  32'sd1,        32'sd2,        1'b0, UNTYPED},
        '{ACT_QUERY, WORD_NONE,     32'sd1,        1'b0, UNTYPED},
        '{ACT_POP,   32'sd0,        WORD_MIN,      1'b0, UNTYPED},
        '{ACT_PUSH,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, UNTYPED},
        '{ACT_PUSH,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, UNTYPED},
        '{ACT_QUERY, 32'sd0,        32'hAAAA_AAAA, 1'b0, UNTYPED},
        '{ACT_POP,   32'sd0,        WORD_MAX,      1'b0, UNTYPED},
        '{ACT_POP,   32'sd0,        32'sd0,        1'b0, UNTYPED},
        '{ACT_POP,   32'sd0,        32'sd1,        1'b0, UNTYPED},
        '{ACT_POP,   32'sd0,        32'h5555_5555, 1'b0, UNTYPED},
        '{ACT_POP,   32'sd0,        32'hAAAA_AAAA, 1'b0, UNTYPED},
        '{ACT_POP,   32'sd0,        32'hAAAA_AAAA, 1'b1, EMPTY_DONE},
        '{ACT_POP,   WORD_NONE,     WORD_NONE,     1'b1, EMPTY_REFUSED},
        '{ACT_PUSH,  WORD_NONE,     WORD_NONE,     1'b0, UNTYPED},
        '{ACT_PUSH,  32'sd3,        32'sd3,        1'b0, UNTYPED},
        '{ACT_CLEAR, 32'sd3,        32'sd3,        1'b1, EMPTY_DONE},
        // the word 3 still sits in the entry RAM but is no longer held
        '{ACT_QUERY, 32'sd0,        32'sd3,        1'b1, EMPTY_DONE}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    send_valid = 1'b0;
    logic [S_DATA_W-1:0]     send_data = '0;
    logic [ACTION_W-1:0]     send_action = '0;
    logic                    take_ready = 1'b0;
    logic                    o_s_axis_tready;
    logic                    o_m_axis_tvalid;
    logic [M_DATA_W-1:0]     o_m_axis_tdata;
    logic [STATUS_W-1:0]     o_m_axis_tuser;

    // Predictor state: its own copy of the circular store.
    logic signed [WORD_W-1:0] store [DEPTH];
    int                       head_idx = 0;
    int                       held = 0;

    fifo_report_t reports_due [$];
    int           mismatches = 0;
    int           results_seen = 0;
    bit           no_gaps = 1'b0;

    fifo_with_search_and_stats_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (send_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (send_data),
        .i_s_axis_tuser  (send_action),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (take_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one action to the model store and return the report it yields.
    function automatic fifo_report_t fifo_report_after(t_action act,
                                                       logic signed [WORD_W-1:0] word,
                                                       logic signed [WORD_W-1:0] key);
        fifo_report_t             rep;
        longint                   sum;
        logic signed [WORD_W-1:0] w;
        rep = EMPTY_DONE;
        sum = 0;
        case (act)
            ACT_PUSH: begin
                if (held == DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    store[(head_idx + held) % DEPTH] = word;
                    held++;
                end
            end
            ACT_POP: begin
                if (held == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    head_idx = (head_idx + 1) % DEPTH;
                    held--;
                end
            end
            ACT_CLEAR: begin
                head_idx = 0;
                held = 0;
            end
            default: ;
        endcase
        for (int i = 0; i < held; i++) begin
            w = store[(head_idx + i) % DEPTH];
            if (i == 0) rep.head = w;
            sum += w;
            if (w > rep.largest) rep.largest = w;
            if (w < rep.smallest) rep.smallest = w;
            if (w == key) rep.found = 1'b1;
        end
        rep.occ = OCC_W'(held);
        rep.total = TOTAL_W'(sum);
        // longint division truncates toward zero, as the block must
        if (held != 0) rep.mean = MEAN_W'((sum * 256) / held);
        return rep;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Words weighted toward the edges of the signed range.
    function automatic logic signed [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return WORD_NONE;
            3: return '0;
            4, 5: return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    // Key that hits a held word often enough for key_found to toggle.
    function automatic logic signed [WORD_W-1:0] pick_key();
        if (held > 0 && $urandom_range(0, 99) < 40)
            return store[(head_idx + $urandom_range(0, held - 1)) % DEPTH];
        return random_word();
    endfunction

    // Present one transfer at the falling edge, predict it at the accepting rising edge.
    task automatic send_item(t_action act, logic signed [WORD_W-1:0] word,
                             logic signed [WORD_W-1:0] key, logic typed, fifo_report_t want);
        int           gap;
        fifo_report_t rep;
        gap = pick_gap();
        if (gap > 0) begin
            send_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        send_valid  <= 1'b1;
        send_data   <= {key, word};
        send_action <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        rep = fifo_report_after(act, word, key);
        reports_due.push_back(typed ? want : rep);
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
        end
    endtask

    // Receiver: ready toggles with random stalls, held high while no_gaps is set.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                take_ready <= 1'b0;
                stall_left--;
            end else begin
                take_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Scoreboard: every master transfer against the oldest report due.
    always @(posedge i_clk) begin
        fifo_report_t got, want;
        if (i_rst_n && o_m_axis_tvalid && take_ready) begin
            results_seen++;
            got = '{status: t_status'(o_m_axis_tuser), head: o_m_axis_tdata[31:0],
                    occ: o_m_axis_tdata[42:32], total: o_m_axis_tdata[84:43],
                    largest: o_m_axis_tdata[116:85], smallest: o_m_axis_tdata[148:117],
                    found: o_m_axis_tdata[149], mean: o_m_axis_tdata[189:150]};
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: transfer with no report due", results_seen);
            end else begin
                want = reports_due.pop_front();
                check_field("status", want.status, got.status);
                check_field("head_value", want.head, got.head);
                check_field("occupancy", want.occ, got.occ);
                check_field("total", want.total, got.total);
                check_field("largest", want.largest, got.largest);
                check_field("smallest", want.smallest, got.smallest);
                check_field("key_found", want.found, got.found);
                check_field("mean_q8", want.mean, got.mean);
                check_field("pad", '0, o_m_axis_tdata[191:190]);
            end
        end
    end

    initial begin
        t_action act;
        int      r;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[n])
            send_item(DIRECTED[n].act, DIRECTED[n].word, DIRECTED[n].key,
                      DIRECTED[n].typed, DIRECTED[n].want);

        // Back-to-back run of INT_MIN pushes: the total goes far negative and
        // the mean sits at its floor.
        no_gaps = 1'b1;
        for (int n = 0; n < 64; n++)
            send_item(ACT_PUSH, WORD_MIN, ($urandom_range(0, 3) == 0) ? WORD_MIN : random_word(),
                      1'b0, UNTYPED);
        no_gaps = 1'b0;
        send_item(ACT_PUSH, WORD_MAX, WORD_MAX, 1'b0, UNTYPED);
        send_item(ACT_QUERY, WORD_MAX, WORD_MIN, 1'b0, UNTYPED);
        repeat (6) send_item(ACT_POP, random_word(), pick_key(), 1'b0, UNTYPED);
        repeat (2) send_item(ACT_PUSH, WORD_MAX, random_word(), 1'b0, UNTYPED);
        send_item(ACT_QUERY, random_word(), WORD_MAX, 1'b0, UNTYPED);
        send_item(ACT_CLEAR, random_word(), WORD_MAX, 1'b0, UNTYPED);

        // Random traffic, held to small occupancy so that each walk stays short.
        repeat (300) begin
            r = $urandom_range(0, 99);
            if (r < 4) act = ACT_CLEAR;
            else if (r < 24) act = ACT_QUERY;
            else if (r < ((held < 40) ? 69 : 39)) act = ACT_PUSH;
            else act = ACT_POP;
            send_item(act, random_word(), pick_key(), 1'b0, UNTYPED);
        end
        send_valid <= 1'b0;

        wait (reports_due.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, with every item at full depth.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
